FILE: sv/dooa_pkg.sv
// Shared types and constants for the door-open unattended alarm.
`default_nettype none

package dooa_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;
    localparam int FR_W       = 8;
    localparam int DUR_W      = 12;
    localparam int COUNT_W    = 24;
    localparam int THR_W      = DUR_W + 1 + FR_W;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ALARM_ENABLE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_RATE       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DURATION_SECONDS = 2'd2;

    // Reset values of the configuration registers
    localparam logic             RST_ALARM_ENABLE     = 1'b1;
    localparam logic [FR_W-1:0]  RST_FRAME_RATE       = 8'd25;
    localparam logic [DUR_W-1:0] RST_DURATION_SECONDS = 12'd10;

    typedef struct packed {
        logic alarm;
        logic frame_abnormal;
        logic window_majority;
    } dooa_result_t;

    // Update request from the frame logic to the window
    typedef struct packed {
        logic upd;
        logic abn;
    } dooa_win_req_t;

endpackage

`default_nettype wire

FILE: sv/door_open_unattended_alarm.sv
// Top level of the door-open unattended alarm.
//
// Takes one frame per clock cycle, each with has_results, door_open_seen and
// target_seen, and returns one result per frame, in order, at the earliest in
// the cycle after acceptance. The abnormal bits of the sliding window live
// in a 1-bit RAM of WINDOW_DEPTH entries; the oldest bit is prefetched every
// cycle and bypassed when the previous frame wrote that same entry, so the
// RAM port pair sustains one frame per cycle. Results wait in a two-entry
// queue, so input is stalled only when two results are pending. No clearing
// pass runs after reset. Configuration writes are always ready and must be
// made while no frame is in flight.
`default_nettype none

module door_open_unattended_alarm import dooa_pkg::*; #(
    parameter int WINDOW_DEPTH = 256
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  has_results,
    input  logic                  door_open_seen,
    input  logic                  target_seen,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  alarm,
    output logic                  frame_abnormal,
    output logic                  window_majority
);

    logic               alarm_enable_reg;
    logic [FR_W-1:0]    frame_rate_reg;
    logic [DUR_W-1:0]   duration_reg;
    logic [COUNT_W-1:0] count_reg, count_next;

    logic               in_acc;
    logic               active;
    logic               abn;
    logic               maj;
    logic [FR_W-1:0]    fr_eff;
    logic [DUR_W:0]     dur_p1;
    logic [THR_W-1:0]   threshold;
    logic [COUNT_W-1:0] count_step;
    logic               fire;
    logic               q_full;
    dooa_win_req_t      win_req;
    dooa_result_t       result;
    dooa_result_t       head;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alarm_enable_reg <= RST_ALARM_ENABLE;
            frame_rate_reg   <= RST_FRAME_RATE;
            duration_reg     <= RST_DURATION_SECONDS;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_ALARM_ENABLE:     alarm_enable_reg <= cfg_data[0];
                CFG_FRAME_RATE:       frame_rate_reg   <= cfg_data[FR_W-1:0];
                CFG_DURATION_SECONDS: duration_reg     <= cfg_data[DUR_W-1:0];
                default:              ;
            endcase
        end
    end

    assign in_stall = q_full;
    assign in_acc   = in_valid && !in_stall;
    assign active   = in_acc && has_results && alarm_enable_reg;
    assign abn      = door_open_seen && !target_seen;

    // Zero frame rate acts as one
    assign fr_eff    = (frame_rate_reg == '0) ? FR_W'(1) : frame_rate_reg;
    assign dur_p1    = {1'b0, duration_reg} + 1'b1;
    assign threshold = THR_W'(dur_p1) * THR_W'(fr_eff);

    assign win_req.upd = active;
    assign win_req.abn = abn;

    dooa_win #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_win (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (win_req),
        .fr       (fr_eff),
        .majority (maj)
    );

    always_comb
    begin
        count_step = count_reg;
        if (maj && (count_reg != COUNT_MAX))
        begin
            count_step = count_reg + 1'b1;
        end
        if (target_seen)
        begin
            count_step = '0;
        end
        fire       = !target_seen && (count_step >= COUNT_W'(threshold));
        count_next = count_reg;
        if (active)
        begin
            count_next = fire ? '0 : count_step;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // Empty or disabled frames return all zeros
    assign result.alarm           = active && fire;
    assign result.frame_abnormal  = active && abn;
    assign result.window_majority = active && maj;

    dooa_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_acc),
        .push_data (result),
        .pop_stall (out_stall),
        .full      (q_full),
        .valid     (out_valid),
        .head      (head)
    );

    assign alarm           = head.alarm;
    assign frame_abnormal  = head.frame_abnormal;
    assign window_majority = head.window_majority;

endmodule

`default_nettype wire

FILE: sv/dooa_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module dooa_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Read returns the old contents on a same-address write
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: sv/dooa_win.sv
// Sliding window of abnormal bits: ring in RAM, running sum and majority test.
`default_nettype none

module dooa_win import dooa_pkg::*; #(
    parameter int WINDOW_DEPTH = 256
) (
    input  logic            clk,
    input  logic            rst_n,
    input  dooa_win_req_t   req,
    input  logic [FR_W-1:0] fr,
    output logic            majority
);

    localparam int PTR_W  = $clog2(WINDOW_DEPTH);
    localparam int FILL_W = $clog2(WINDOW_DEPTH + 1);
    localparam int CMP_W  = (FILL_W > FR_W) ? FILL_W : FR_W;

    logic [PTR_W-1:0]  wp_reg, wp_next;
    logic [PTR_W-1:0]  rd_reg, rd_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [FILL_W-1:0] sum_reg, sum_next;
    logic              fwd_hit_reg, fwd_hit_next;
    logic              fwd_bit_reg, fwd_bit_next;

    logic              ram_rdata;
    logic              oldest;
    logic              drop;
    logic [FILL_W-1:0] sum_after;

    function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(WINDOW_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // Oldest bit is prefetched every cycle; take the bypass when the
    // previous cycle wrote the address being read.
    assign oldest = fwd_hit_reg ? fwd_bit_reg : ram_rdata;

    assign drop = (fill_reg != '0) &&
                  ((CMP_W'(fill_reg) > CMP_W'(fr)) ||
                   (fill_reg >= FILL_W'(WINDOW_DEPTH)));

    assign sum_after = sum_reg - FILL_W'(drop & oldest) + FILL_W'(req.abn);
    assign majority  = CMP_W'(sum_after) > CMP_W'(fr >> 1);

    always_comb
    begin
        wp_next      = wp_reg;
        rd_next      = rd_reg;
        fill_next    = fill_reg;
        sum_next     = sum_reg;
        if (req.upd)
        begin
            wp_next  = ring_next(wp_reg);
            rd_next  = drop ? ring_next(rd_reg) : rd_reg;
            fill_next = drop ? fill_reg : fill_reg + 1'b1;
            sum_next = sum_after;
        end
        fwd_hit_next = req.upd && (rd_next == wp_reg);
        fwd_bit_next = req.abn;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg      <= '0;
            rd_reg      <= '0;
            fill_reg    <= '0;
            sum_reg     <= '0;
            fwd_hit_reg <= 1'b0;
            fwd_bit_reg <= 1'b0;
        end
        else
        begin
            wp_reg      <= wp_next;
            rd_reg      <= rd_next;
            fill_reg    <= fill_next;
            sum_reg     <= sum_next;
            fwd_hit_reg <= fwd_hit_next;
            fwd_bit_reg <= fwd_bit_next;
        end
    end

    dooa_ram #(
        .WIDTH (1),
        .DEPTH (WINDOW_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (req.upd),
        .waddr (wp_reg),
        .wdata (req.abn),
        .raddr (rd_next),
        .rdata (ram_rdata)
    );

endmodule

`default_nettype wire

FILE: sv/dooa_outq.sv
// Two-entry result queue between the frame logic and the output channel.
`default_nettype none

module dooa_outq import dooa_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  dooa_result_t push_data,
    input  logic         pop_stall,
    output logic         full,
    output logic         valid,
    output dooa_result_t head
);

    logic [1:0]   cnt_reg, cnt_next;
    dooa_result_t slot0_reg, slot0_next;
    dooa_result_t slot1_reg, slot1_next;
    logic         pop;

    assign valid = (cnt_reg != 2'd0);
    assign full  = (cnt_reg == 2'd2);
    assign head  = slot0_reg;
    assign pop   = valid && !pop_stall;

    always_comb
    begin
        cnt_next   = cnt_reg;
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        priority if (push && pop)
        begin
            if (cnt_reg == 2'd2)
            begin
                slot0_next = slot1_reg;
                slot1_next = push_data;
            end
            else
            begin
                slot0_next = push_data;
            end
        end
        else if (push)
        begin
            cnt_next = cnt_reg + 2'd1;
            if (cnt_reg == 2'd0)
            begin
                slot0_next = push_data;
            end
            else
            begin
                slot1_next = push_data;
            end
        end
        else if (pop)
        begin
            cnt_next   = cnt_reg - 2'd1;
            slot0_next = slot1_reg;
        end
        else
        begin
            // Hold count and slots
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

endmodule

`default_nettype wire

FILE: sv/dooa_checker.sv
// Port-level checks for the door-open unattended alarm, bound to the top level.
`default_nettype none

module dooa_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_stall,
    input logic has_results,
    input logic door_open_seen,
    input logic target_seen,
    input logic out_valid,
    input logic out_stall,
    input logic alarm,
    input logic frame_abnormal,
    input logic window_majority
);

    logic in_acc_empty;

    // A transaction taken while no result is pending shows up next cycle
    assign in_acc_empty = in_valid && !in_stall && !out_valid;

    a_stall_only_when_pending: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with no result pending");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(alarm) &&
            $stable(frame_abnormal) && $stable(window_majority)))
        else $error("stalled result changed or dropped");

    a_empty_frame_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc_empty && !has_results) |=>
            (out_valid && !alarm && !frame_abnormal && !window_majority))
        else $error("empty frame produced a nonzero result");

    a_target_blocks_alarm: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc_empty && target_seen) |=> (out_valid && !alarm && !frame_abnormal))
        else $error("alarm or abnormal flag raised with target present");

    a_closed_door_normal: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc_empty && !door_open_seen) |=> (out_valid && !frame_abnormal))
        else $error("abnormal flag raised with door closed");

endmodule

bind door_open_unattended_alarm dooa_checker u_dooa_checker (.*);

`default_nettype wire

FILE: verif/door_open_unattended_alarm_tb.sv
// Self-checking testbench for the door-open unattended alarm block.
module door_open_unattended_alarm_tb;
    import dooa_pkg::*;

    localparam int WIN_DEPTH = 256;
    localparam int unsigned HOLD_CYCLES = 200;

    logic                  clk;
    logic                  rst_n          = 1'b0;
    logic                  cfg_valid      = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index      = CFG_ALARM_ENABLE;
    logic [CFG_DATA_W-1:0] cfg_data       = '0;
    logic                  in_valid       = 1'b0;
    logic                  in_stall;
    logic                  has_results    = 1'b0;
    logic                  door_open_seen = 1'b0;
    logic                  target_seen    = 1'b0;
    logic                  out_valid;
    logic                  out_stall      = 1'b0;
    logic                  alarm;
    logic                  frame_abnormal;
    logic                  window_majority;

    // Mirror of the configuration registers
    logic             cfg_enable = RST_ALARM_ENABLE;
    logic [FR_W-1:0]  cfg_rate   = RST_FRAME_RATE;
    logic [DUR_W-1:0] cfg_dur    = RST_DURATION_SECONDS;

    // Mirror of the window and run counter
    bit               win_bits [WIN_DEPTH];
    int unsigned      win_ptr  = 0;
    int unsigned      win_fill = 0;
    int unsigned      win_sum  = 0;
    logic [COUNT_W-1:0] run_len = '0;

    dooa_result_t verdicts_due [$];
    int           mismatches   = 0;
    bit           src_gaps_on  = 1'b1;
    bit           rx_stalls_on = 1'b1;
    bit           hold_req     = 1'b0;

    door_open_unattended_alarm #(
        .WINDOW_DEPTH(WIN_DEPTH)
    ) i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .has_results    (has_results),
        .door_open_seen (door_open_seen),
        .target_seen    (target_seen),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .alarm          (alarm),
        .frame_abnormal (frame_abnormal),
        .window_majority(window_majority)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5000000;
        $display("door_open_unattended_alarm_tb failed");
        $finish;
    end

    // Mostly short idle stretches, now and then a long one
    function automatic int unsigned pick_idle();
        int unsigned roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Advance the window and run counter for a non-empty frame while enabled; return the verdict
    function automatic dooa_result_t judge_frame(input logic has, input logic door,
                                                 input logic tgt);
        dooa_result_t v;
        int unsigned  rate;
        int unsigned  thr;
        logic         abn;
        v = '0;
        if (!has || !cfg_enable)
            return v;
        rate = (cfg_rate == 0) ? 1 : int'(cfg_rate);
        abn  = door && !tgt;
        if (win_fill > rate || win_fill >= WIN_DEPTH)
            win_sum -= win_bits[(win_ptr + WIN_DEPTH - win_fill) % WIN_DEPTH];
        else
            win_fill++;
        win_bits[win_ptr] = abn;
        win_sum += abn;
        win_ptr = (win_ptr + 1) % WIN_DEPTH;
        v.window_majority = win_sum > rate / 2;
        if (v.window_majority && run_len != COUNT_MAX)
            run_len++;
        if (tgt)
            run_len = '0;
        thr = (int'(cfg_dur) + 1) * rate;
        if (!tgt && run_len >= thr)
        begin
            run_len = '0;
            v.alarm = 1'b1;
        end
        v.frame_abnormal = abn;
        return v;
    endfunction

    // Leaves cfg_valid high; the next frame or write drives it again
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            CFG_ALARM_ENABLE:     cfg_enable = data[0];
            CFG_FRAME_RATE:       cfg_rate   = data[FR_W-1:0];
            CFG_DURATION_SECONDS: cfg_dur    = data[DUR_W-1:0];
            default: ;
        endcase
    endtask

    task automatic send_frame(input logic has, input logic door, input logic tgt);
        int unsigned gap;
        cfg_valid      <= 1'b0;
        in_valid       <= 1'b1;
        has_results    <= has;
        door_open_seen <= door;
        target_seen    <= tgt;
        do @(posedge clk); while (in_stall);
        verdicts_due.insert(verdicts_due.size(), judge_frame(has, door, tgt));
        gap = src_gaps_on ? pick_idle() : 0;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Runs of abnormal frames broken by random frames, empty frames as noise
    task automatic send_mix(input int unsigned n, input int unsigned abn_pct);
        int unsigned roll;
        repeat (n)
        begin
            roll = $urandom_range(0, 99);
            if (roll < abn_pct)
                send_frame(1'b1, 1'b1, 1'b0);
            else if (roll < abn_pct + 3)
                send_frame(1'b0, 1'($urandom), 1'($urandom));
            else
                send_frame(1'b1, 1'($urandom), 1'($urandom));
        end
    endtask

    // Drop valid and hold until every due result has come back
    task automatic settle();
        in_valid <= 1'b0;
        while (verdicts_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_directed();
        for (int i = 0; i < 4; i++)
            send_frame(1'b0, i[1], i[0]);
        for (int i = 0; i < 4; i++)
            send_frame(1'b1, i[1], i[0]);
        settle();
        // shortest window and zero duration: every abnormal frame alarms
        write_reg(CFG_FRAME_RATE, 12'd1);
        write_reg(CFG_DURATION_SECONDS, 12'd0);
        send_frame(1'b1, 1'b1, 1'b0);
        send_frame(1'b1, 1'b1, 1'b0);
        send_frame(1'b1, 1'b1, 1'b1);
        send_frame(1'b1, 1'b1, 1'b0);
        settle();
        // zero frame rate behaves as one
        write_reg(CFG_FRAME_RATE, 12'd0);
        repeat (3) send_frame(1'b1, 1'b1, 1'b0);
        settle();
        write_reg(CFG_ALARM_ENABLE, 12'd0);
        send_frame(1'b1, 1'b1, 1'b0);
        send_frame(1'b1, 1'b0, 1'b1);
        send_frame(1'b1, 1'b1, 1'b1);
        settle();
        write_reg(CFG_ALARM_ENABLE, 12'd1);
    endtask

    task automatic test_full_window();
        settle();
        write_reg(CFG_FRAME_RATE, 12'd255);
        write_reg(CFG_DURATION_SECONDS, 12'd0);
        send_mix(300, 90);
        settle();
        // lower the rate: the full window keeps its length
        write_reg(CFG_FRAME_RATE, 12'd3);
        send_mix(40, 80);
    endtask

    task automatic test_random_rates();
        for (int p = 0; p < 6; p++)
        begin
            settle();
            write_reg(CFG_FRAME_RATE, 12'($urandom_range(1, 6)));
            write_reg(CFG_DURATION_SECONDS, 12'($urandom_range(0, 2)));
            src_gaps_on  = (p != 2);
            rx_stalls_on = (p != 2);
            send_mix(20, 85);
        end
        src_gaps_on  = 1'b1;
        rx_stalls_on = 1'b1;
    endtask

    task automatic test_extremes();
        settle();
        write_reg(CFG_DURATION_SECONDS, 12'd3600);
        write_reg(CFG_FRAME_RATE, 12'd255);
        send_mix(20, 90);
        settle();
        write_reg(CFG_DURATION_SECONDS, 12'd4095);
        write_reg(CFG_FRAME_RATE, 12'd1);
        send_mix(15, 90);
    endtask

    task automatic test_backpressure();
        settle();
        write_reg(CFG_FRAME_RATE, 12'd4);
        write_reg(CFG_DURATION_SECONDS, 12'd1);
        src_gaps_on = 1'b0;
        hold_req    = 1'b1;
        send_mix(40, 85);
        settle();
        src_gaps_on = 1'b1;
        send_mix(20, 85);
    endtask

    // Receiver stall generator; a hold request stalls for HOLD_CYCLES
    initial
    begin : rx_stall_gen
        int unsigned left;
        int unsigned r;
        left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                left     = HOLD_CYCLES;
            end
            if (left != 0)
            begin
                out_stall <= 1'b1;
                left--;
            end
            else if (!rx_stalls_on)
                out_stall <= 1'b0;
            else
            begin
                r = pick_idle();
                out_stall <= (r != 0);
                if (r != 0)
                    left = r - 1;
            end
        end
    end

    always @(posedge clk)
    begin
        dooa_result_t want;
        if (rst_n && out_valid === 1'b1 && !out_stall)
        begin
            if (verdicts_due.size() == 0)
            begin
                $error("result transaction with none expected");
                mismatches++;
            end
            else
            begin
                want = verdicts_due[0];
                verdicts_due.delete(0);
                if (alarm !== want.alarm)
                begin
                    $error("alarm: expected %0b, got %0b", want.alarm, alarm);
                    mismatches++;
                end
                if (frame_abnormal !== want.frame_abnormal)
                begin
                    $error("frame_abnormal: expected %0b, got %0b",
                           want.frame_abnormal, frame_abnormal);
                    mismatches++;
                end
                if (window_majority !== want.window_majority)
                begin
                    $error("window_majority: expected %0b, got %0b",
                           want.window_majority, window_majority);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_full_window();
        test_random_rates();
        test_extremes();
        test_backpressure();
        settle();
        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("door_open_unattended_alarm_tb passed");
        else
            $display("door_open_unattended_alarm_tb failed");
        $finish;
    end

endmodule
